// File: hdl/fwmg_pkg.sv
// ----------------------------------------------------------------------------
// fwmg_pkg
// Shared types and constants for the fuzzy word match grader.
// ----------------------------------------------------------------------------
package fwmg_pkg;

    typedef logic [7:0] char_t;
    typedef logic [1:0] cell_t;
    typedef logic [1:0] grade_t;
    typedef logic [1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t CFG_QUERY_LOW  = 2'd0;
    localparam cfg_index_t CFG_QUERY_MID  = 2'd1;
    localparam cfg_index_t CFG_QUERY_HIGH = 2'd2;
    localparam cfg_index_t CFG_QUERY_LEN  = 2'd3;

    localparam int CFG_DATA_W    = 64;
    localparam int QUERY_HIGH_W  = 56;
    localparam int QUERY_LEN_W   = 5;
    localparam int QUERY_CHARS   = 23;
    localparam int QUERY_FLAT_W  = 2 * CFG_DATA_W + QUERY_HIGH_W;

    localparam logic [QUERY_LEN_W-1:0] QUERY_LEN_RESET = 5'd1;

    // grades
    localparam grade_t GRADE_NONE  = 2'd0;
    localparam grade_t GRADE_NEAR  = 2'd1;
    localparam grade_t GRADE_EXACT = 2'd2;

    // grading thresholds
    localparam logic [QUERY_LEN_W-1:0] PREFIX_MIN_LEN  = 5'd4;
    localparam logic [QUERY_LEN_W-1:0] TYPO_MIN_LEN    = 5'd5;
    localparam logic [QUERY_LEN_W-1:0] LONG_QUERY_LEN  = 5'd8;
    localparam cell_t                  MAXD_SHORT      = 2'd1;
    localparam cell_t                  MAXD_LONG       = 2'd2;

    // distance cells saturate here
    localparam cell_t CELL_MAX = 2'd3;
    localparam int    LOOKBACK = 3;

endpackage

// File: hdl/fuzzy_word_match_grader_core.sv
// ----------------------------------------------------------------------------
// fuzzy_word_match_grader_core
// Streams candidate words against a configured query and grades each word.
// ----------------------------------------------------------------------------
// Usage:
//   The query word (up to 23 bytes) and its length are loaded through the
//   cfg_we / cfg_index / cfg_wdata write port while no word is in flight.
//   Candidate characters arrive on the s_ channel, one request per
//   character, s_end_of_word on the last one. Each character updates one
//   row of a saturating edit-distance table held in flip-flops; all cells
//   of the row update together, using a three-cell lookback
//   instead of the left-to-right chain.
//   A word's last character produces one request on the m_ channel carrying
//   m_match_grade; other characters produce none.
//   Throughput: one character per cycle, except while a last character stalls.
//   A last character's grade is registered once the output register is free.
//   The input register keeps accepting while a grade waits on m_ready; only
//   a second last character stalls behind an untaken grade.
//   Reset (aresetn low, synchronous) clears the query to length 1, the row
//   to its initial values and both channels to empty.
// ----------------------------------------------------------------------------
module fuzzy_word_match_grader_core #(
    parameter int WORD_BUFFER = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_we,
    input  fwmg_pkg::cfg_index_t                   cfg_index,
    input  logic [fwmg_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  fwmg_pkg::char_t                        s_char_code,
    input  logic                                   s_end_of_word,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output fwmg_pkg::grade_t                       m_match_grade
);

    localparam int CW       = $clog2(WORD_BUFFER);
    localparam int LAST_POS = WORD_BUFFER - 1;
    localparam int LW       = fwmg_pkg::QUERY_LEN_W;

    // configuration
    logic [fwmg_pkg::CFG_DATA_W-1:0]   q_low_reg;
    logic [fwmg_pkg::CFG_DATA_W-1:0]   q_mid_reg;
    logic [fwmg_pkg::QUERY_HIGH_W-1:0] q_high_reg;
    logic [LW-1:0]                     q_len_reg;
    logic [fwmg_pkg::QUERY_FLAT_W-1:0] q_flat;
    fwmg_pkg::char_t                   qchar [WORD_BUFFER];

    // input register
    logic            in_valid_reg;
    fwmg_pkg::char_t in_char_reg;
    logic            in_last_reg;

    // word state
    fwmg_pkg::cell_t row_reg  [WORD_BUFFER];
    fwmg_pkg::cell_t row_next [WORD_BUFFER];
    fwmg_pkg::cell_t row_upd  [WORD_BUFFER];
    fwmg_pkg::cell_t row_eval [WORD_BUFFER];
    logic [2:0]      t_cell   [WORD_BUFFER];
    logic [CW-1:0]   len_reg, len_next, len_eval;
    logic            prefix_reg, prefix_next, prefix_eval;

    // output register
    logic             m_valid_reg, m_valid_next;
    fwmg_pkg::grade_t grade_reg, grade_next;

    logic             out_free, commit, in_range;
    logic [LW-1:0]    lq_eff, lc_ext;
    logic [CW-1:0]    lq_idx;
    fwmg_pkg::cell_t  lq_cell, maxd;

    assign q_flat = {q_high_reg, q_mid_reg, q_low_reg};

    for (genvar p = 0; p < WORD_BUFFER; p++) begin : g_qchar
        if (p < fwmg_pkg::QUERY_CHARS) begin : g_reg
            assign qchar[p] = q_flat[8*p +: 8];
        end else begin : g_zero
            assign qchar[p] = '0;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign commit   = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || commit;
    assign m_valid  = m_valid_reg;
    assign m_match_grade = grade_reg;

    assign in_range = len_reg < CW'(LAST_POS);
    assign lq_eff   = (q_len_reg > LW'(LAST_POS)) ? LW'(LAST_POS) : q_len_reg;
    assign lq_idx   = lq_eff[CW-1:0];

    // row update: t = min(up+1, diag+cost), then a bounded left lookback
    always_comb begin
        logic [2:0] best;
        logic [2:0] cand;
        t_cell[0] = (len_reg >= CW'(2)) ? 3'd3 : 3'(len_reg) + 3'd1;
        for (int j = 1; j < WORD_BUFFER; j++) begin
            best = {1'b0, row_reg[j]} + 3'd1;
            cand = {1'b0, row_reg[j-1]} + {2'b00, (qchar[j-1] != in_char_reg)};
            t_cell[j] = (cand < best) ? cand : best;
        end
        for (int j = 0; j < WORD_BUFFER; j++) begin
            best = t_cell[j];
            for (int k = 1; k <= fwmg_pkg::LOOKBACK; k++) begin
                if (k <= j) begin
                    cand = t_cell[j-k] + 3'(k);
                    if (cand < best) begin
                        best = cand;
                    end
                end
            end
            row_upd[j] = (best > 3'(fwmg_pkg::CELL_MAX)) ? fwmg_pkg::CELL_MAX : best[1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_BUFFER; j++) begin
            row_eval[j] = in_range ? row_upd[j] : row_reg[j];
        end
    end

    assign len_eval    = in_range ? len_reg + CW'(1) : len_reg;
    assign prefix_eval = prefix_reg &&
                         !(in_range && (LW'(len_reg) < lq_eff) && (qchar[len_reg] != in_char_reg));
    assign lc_ext      = LW'(len_eval);
    assign lq_cell     = row_eval[lq_idx];
    assign maxd        = (lq_eff >= fwmg_pkg::LONG_QUERY_LEN) ? fwmg_pkg::MAXD_LONG
                                                              : fwmg_pkg::MAXD_SHORT;

    always_comb begin
        if (lq_eff == lc_ext && prefix_eval) begin
            grade_next = fwmg_pkg::GRADE_EXACT;
        end else if (lq_eff >= fwmg_pkg::PREFIX_MIN_LEN && lc_ext >= fwmg_pkg::PREFIX_MIN_LEN
                     && prefix_eval) begin
            grade_next = fwmg_pkg::GRADE_NEAR;
        end else if (lq_eff >= fwmg_pkg::TYPO_MIN_LEN && lc_ext >= fwmg_pkg::TYPO_MIN_LEN
                     && lq_cell <= maxd) begin
            grade_next = fwmg_pkg::GRADE_NEAR;
        end else begin
            grade_next = fwmg_pkg::GRADE_NONE;
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_BUFFER; j++) begin
            row_next[j] = row_reg[j];
        end
        len_next    = len_reg;
        prefix_next = prefix_reg;
        if (commit) begin
            if (in_last_reg) begin
                for (int j = 0; j < WORD_BUFFER; j++) begin
                    row_next[j] = (j < 3) ? 2'(j) : fwmg_pkg::CELL_MAX;
                end
                len_next    = '0;
                prefix_next = 1'b1;
            end else begin
                for (int j = 0; j < WORD_BUFFER; j++) begin
                    row_next[j] = row_eval[j];
                end
                len_next    = len_eval;
                prefix_next = prefix_eval;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_low_reg    <= '0;
            q_mid_reg    <= '0;
            q_high_reg   <= '0;
            q_len_reg    <= fwmg_pkg::QUERY_LEN_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            len_reg      <= '0;
            prefix_reg   <= 1'b1;
            for (int j = 0; j < WORD_BUFFER; j++) begin
                row_reg[j] <= (j < 3) ? 2'(j) : fwmg_pkg::CELL_MAX;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    fwmg_pkg::CFG_QUERY_LOW:  q_low_reg  <= cfg_wdata;
                    fwmg_pkg::CFG_QUERY_MID:  q_mid_reg  <= cfg_wdata;
                    fwmg_pkg::CFG_QUERY_HIGH: q_high_reg <= cfg_wdata[fwmg_pkg::QUERY_HIGH_W-1:0];
                    fwmg_pkg::CFG_QUERY_LEN:  q_len_reg  <= cfg_wdata[LW-1:0];
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
            prefix_reg  <= prefix_next;
            for (int j = 0; j < WORD_BUFFER; j++) begin
                row_reg[j] <= row_next[j];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_end_of_word;
        end
        if (commit && in_last_reg) begin
            grade_reg <= grade_next;
        end
    end

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= CW'(LAST_POS))
        else $error("candidate length past buffer");

    a_row0_tracks_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg >= CW'(3)) ? (row_reg[0] == fwmg_pkg::CELL_MAX)
                            : (row_reg[0] == 2'(len_reg)))
        else $error("first row cell out of step with length");

    a_word_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && in_last_reg |=> len_reg == '0 && prefix_reg)
        else $error("word state not cleared after grade");

    a_grade_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> grade_reg != 2'd3)
        else $error("illegal grade code");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> !(commit && in_last_reg) || $past(commit) == 1'b0
                                    || m_ready || !m_valid_reg)
        else $error("grade overwritten while stalled");

endmodule
